FILE: src/swl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swl_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 5;
   localparam int SIZE_W        = 5;
   localparam int ADDR_W        = 3;
   localparam int CSR_W         = 32;

   localparam logic              ORDER_RESET = 1'b1;
   localparam logic [SIZE_W-1:0] SIZE_RESET  = 5'd16;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_ORDER = 1'b0,
      REG_SIZE  = 1'b1
   } swl_reg_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } swl_op_type;

   // command broadcast from the sequencer to every cell
   typedef struct packed {
      logic       capture;
      logic       apply;
      swl_op_type op;
      logic       desc;
   } swl_cmd_type;

endpackage

`default_nettype wire

FILE: src/swl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module swl_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire swl_pkg::swl_cmd_type               cmd,
   input  wire logic signed [swl_pkg::DATA_W-1:0]  op_value,
   input  wire logic                               in_use,
   input  wire logic                               is_last,
   input  wire logic                               after_self,
   input  wire logic                               after_prev,
   input  wire logic signed [swl_pkg::DATA_W-1:0]  prev_entry,
   input  wire logic signed [swl_pkg::DATA_W-1:0]  next_entry,
   output logic                                    hit,
   output logic signed [swl_pkg::DATA_W-1:0]       entry
);
   import swl_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     hit_ff;
   logic                     hit_in;
   logic                     beats;

   always_comb begin
      beats = cmd.desc ? (op_value > entry_ff) : (entry_ff > op_value);
      case (cmd.op)
         OP_INSERT: hit_in = in_use & (is_last | beats);
         OP_DELETE: hit_in = in_use & (op_value == entry_ff);
         default:   hit_in = 1'b0;
      endcase
   end

   // insert: the first marked slot loads the value, later marked slots take the
   // neighbor above; delete: marked slots take the neighbor below, last slot holds
   always_comb begin
      entry_in = entry_ff;
      if (cmd.apply) begin
         case (cmd.op)
            OP_INSERT: begin
               if (in_use & after_self) begin
                  entry_in = after_prev ? prev_entry : op_value;
               end
            end
            OP_DELETE: begin
               if (in_use & ~is_last & after_self) begin
                  entry_in = next_entry;
               end
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_ff <= hit_in;
      end
   end

   assign hit   = hit_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

FILE: src/swl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module swl_ctrl #(
   parameter int LIST_DEPTH = swl_pkg::DEFAULT_DEPTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_mode,
   input  wire logic signed [swl_pkg::DATA_W-1:0]    req_value,
   input  wire logic                                 desc,
   input  wire logic [$clog2(LIST_DEPTH+1)-1:0]      used_n,
   input  wire logic [LIST_DEPTH-1:0]                hits,
   output logic [LIST_DEPTH-1:0]                     after,
   output swl_pkg::swl_cmd_type                      cmd,
   output logic signed [swl_pkg::DATA_W-1:0]         cmd_value,
   input  wire logic signed [swl_pkg::DATA_W-1:0]    first_entry,
   input  wire logic signed [swl_pkg::DATA_W-1:0]    last_entry,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [swl_pkg::POS_W-1:0]                 rsp_position,
   output logic                                      rsp_found,
   output logic signed [swl_pkg::DATA_W-1:0]         rsp_dropped_value,
   output logic signed [swl_pkg::DATA_W-1:0]         rsp_first_value,
   output logic signed [swl_pkg::DATA_W-1:0]         rsp_last_value
);
   import swl_pkg::*;

   localparam int PW = $clog2(LIST_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_APPLY,
      ST_SHOW
   } state_type;

   state_type                state_ff;
   swl_op_type               op_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [LIST_DEPTH-1:0]    after_ff;
   logic [LIST_DEPTH-1:0]    after_in;
   logic [LIST_DEPTH-1:0]    first_hit;
   logic [PW-1:0]            pos_enc;
   logic [POS_W-1:0]         pos_ff;
   logic [POS_W-1:0]         pos_in;
   logic                     found_ff;
   logic                     found_in;
   logic signed [DATA_W-1:0] dropped_ff;
   logic                     rsp_valid_ff;
   logic [POS_W-1:0]         rsp_position_ff;
   logic                     rsp_found_ff;
   logic signed [DATA_W-1:0] rsp_dropped_ff;
   logic signed [DATA_W-1:0] rsp_first_ff;
   logic signed [DATA_W-1:0] rsp_last_ff;
   logic                     accept;
   logic                     show_load;

   assign accept    = req_valid & (state_ff == ST_IDLE);
   assign show_load = (state_ff == ST_SHOW) & (~rsp_valid_ff | ~rsp_stall);

   // x | -x marks the lowest hit and every slot above it
   always_comb begin
      after_in  = hits | (~hits + 1'b1);
      first_hit = hits & (~hits + 1'b1);
      pos_enc   = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         if (first_hit[k]) begin
            pos_enc = pos_enc | PW'(k);
         end
      end
      found_in = |hits;
      pos_in   = found_in ? POS_W'(pos_enc) : POS_W'(used_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (show_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff & ~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= swl_op_type'(req_mode);
                  value_ff <= req_value;
                  state_ff <= ST_MARK;
               end
            end
            ST_MARK: begin
               after_ff <= after_in;
               pos_ff   <= pos_in;
               found_ff <= found_in;
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               dropped_ff <= (op_ff == OP_INSERT) ? last_entry : '0;
               state_ff   <= ST_SHOW;
            end
            ST_SHOW: begin
               if (show_load) begin
                  rsp_position_ff <= pos_ff;
                  rsp_found_ff    <= found_ff;
                  rsp_dropped_ff  <= dropped_ff;
                  rsp_first_ff    <= first_entry;
                  rsp_last_ff     <= last_entry;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.capture = accept;
      cmd.apply   = (state_ff == ST_APPLY);
      cmd.op      = accept ? swl_op_type'(req_mode) : op_ff;
      cmd.desc    = desc;
      cmd_value   = accept ? req_value : value_ff;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign after             = after_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_dropped_value = rsp_dropped_ff;
   assign rsp_first_value   = rsp_first_ff;
   assign rsp_last_value    = rsp_last_ff;

   a_accept_mark: assert property (@(posedge clock) disable iff (reset)
      (req_valid && state_ff == ST_IDLE) |=> (state_ff == ST_MARK))
      else $error("accepted item did not start marking");

   a_insert_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && op_ff == OP_INSERT) |-> found_ff)
      else $error("insert found no slot");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && found_ff) |-> (pos_ff < POS_W'(used_n)))
      else $error("position beyond used slots");

   a_after_contig: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> (((after_ff << 1) & ~after_ff) == '0))
      else $error("shift mask is not contiguous");

endmodule

`default_nettype wire

FILE: src/sorted_window_list.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted window list: a row of LIST_DEPTH cells holding signed 32-bit entries,
// kept in descending or ascending order (csr register 0), of which the first
// used_size slots are in use (csr register 1, address 4).
// Input channel req_*: mode 0 inserts req_value, mode 1 deletes the first
// entry equal to req_value. Every item gives exactly one result item on rsp_*:
// position, found flag, dropped entry and the first and last used entries.
// Timing: an item is accepted when req_valid is high and req_stall low. Then,
// in order, each cell captures its compare of the value with its entry, a shift
// mask is formed from the hit row with one wide add, all cells shift at once,
// and the result is loaded and rsp_valid rises. req_stall stays high from
// acceptance until that result is loaded: a new item is taken only after the
// compare / mask / shift / report sequence of the last one is through.
// The result register parts the two sides: the next item is taken while a
// result waits; if rsp_stall holds the previous result, the new one waits in
// the report step and req_stall stays high until it is loaded.
// Reset (synchronous, active high) clears all entries to zero, sets the order
// to descending and used_size to 16, and empties the result register.
// Configuration must be written only while no item is in flight.

module sorted_window_list #(
   parameter int LIST_DEPTH = swl_pkg::DEFAULT_DEPTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_mode,
   input  wire logic signed [swl_pkg::DATA_W-1:0]    req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [swl_pkg::POS_W-1:0]                 rsp_position,
   output logic                                      rsp_found,
   output logic signed [swl_pkg::DATA_W-1:0]         rsp_dropped_value,
   output logic signed [swl_pkg::DATA_W-1:0]         rsp_first_value,
   output logic signed [swl_pkg::DATA_W-1:0]         rsp_last_value,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [swl_pkg::ADDR_W-1:0]           paddr,
   input  wire logic [swl_pkg::CSR_W-1:0]            pwdata,
   output logic [swl_pkg::CSR_W-1:0]                 prdata,
   output logic                                      pready
);
   import swl_pkg::*;

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;

   logic                     order_ff;
   logic [SIZE_W-1:0]        size_ff;
   logic                     csr_write;
   swl_reg_type              csr_index;
   logic [SW-1:0]            size_ext;
   logic [CW-1:0]            used_n;
   logic [LIST_DEPTH-1:0]    in_use;
   logic [LIST_DEPTH-1:0]    is_last;
   logic [LIST_DEPTH-1:0]    hits;
   logic [LIST_DEPTH-1:0]    after;
   swl_cmd_type              cmd;
   logic signed [DATA_W-1:0] cmd_value;
   logic signed [DATA_W-1:0] entry_w      [LIST_DEPTH];
   logic signed [DATA_W-1:0] prev_entry_w [LIST_DEPTH];
   logic signed [DATA_W-1:0] next_entry_w [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]    after_prev_w;
   logic signed [DATA_W-1:0] last_sel;

   // Configuration registers; pready is always high, low address bits ignored
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = swl_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         size_ff  <= SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ORDER: order_ff <= pwdata[0];
            REG_SIZE:  size_ff  <= pwdata[SIZE_W-1:0];
            default:   order_ff <= order_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_ORDER: prdata = CSR_W'(order_ff);
         REG_SIZE:  prdata = CSR_W'(size_ff);
         default:   prdata = '0;
      endcase
   end

   // Slots in use: zero counts as one, anything beyond the row saturates
   always_comb begin
      size_ext = SW'(size_ff);
      if (size_ff == '0) begin
         used_n = CW'(1);
      end else if (size_ext > SW'(LIST_DEPTH)) begin
         used_n = CW'(LIST_DEPTH);
      end else begin
         used_n = CW'(size_ext);
      end
      for (int k = 0; k < LIST_DEPTH; k++) begin
         in_use[k]  = (CW'(k) < used_n);
         is_last[k] = (CW'(k + 1) == used_n);
      end
   end

   // Row of cells; each sees its neighbors' entries and the mask bit above it
   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign prev_entry_w[k] = '0;
         assign after_prev_w[k] = 1'b0;
      end else begin : g_body
         assign prev_entry_w[k] = entry_w[k-1];
         assign after_prev_w[k] = after[k-1];
      end
      if (k == LIST_DEPTH - 1) begin : g_tail
         assign next_entry_w[k] = '0;
      end else begin : g_link
         assign next_entry_w[k] = entry_w[k+1];
      end

      swl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .op_value   (cmd_value),
         .in_use     (in_use[k]),
         .is_last    (is_last[k]),
         .after_self (after[k]),
         .after_prev (after_prev_w[k]),
         .prev_entry (prev_entry_w[k]),
         .next_entry (next_entry_w[k]),
         .hit        (hits[k]),
         .entry      (entry_w[k])
      );
   end

   // Pick the last used entry: AND-OR over the row, one slot flagged
   always_comb begin
      last_sel = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         last_sel = last_sel | (entry_w[k] & {DATA_W{is_last[k]}});
      end
   end

   swl_ctrl #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .desc              (order_ff),
      .used_n            (used_n),
      .hits              (hits),
      .after             (after),
      .cmd               (cmd),
      .cmd_value         (cmd_value),
      .first_entry       (entry_w[0]),
      .last_entry        (last_sel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position      (rsp_position),
      .rsp_found         (rsp_found),
      .rsp_dropped_value (rsp_dropped_value),
      .rsp_first_value   (rsp_first_value),
      .rsp_last_value    (rsp_last_value)
   );

endmodule

`default_nettype wire

FILE: tb/sorted_window_list_tb.sv
`timescale 1ns / 1ps

module sorted_window_list_tb;
   import swl_pkg::*;

   localparam int DEPTH = DEFAULT_DEPTH;

   // One result item as the block reports it.
   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic              found;
      logic [DATA_W-1:0] dropped;
      logic [DATA_W-1:0] first;
      logic [DATA_W-1:0] last;
   } slot_report_type;

   // Directed row: when typed is set, the report fields hold the result read
   // straight off the list contents; otherwise the list mirror decides.
   typedef struct packed {
      logic              typed;
      swl_op_type        op;
      logic [DATA_W-1:0] value;
      slot_report_type   report;
   } directed_row_type;

   localparam int N_DIRECTED = 20;

   // The first six rows start from the cleared, descending, 16-slot list.
   directed_row_type directed_rows [N_DIRECTED] = '{
      // insert beats the zero in slot 0
      '{1'b1, OP_INSERT, 32'd5,        '{5'd0,  1'b1, 32'd0, 32'd5,        32'd0}},
      // delete from the front; last slot keeps its old value
      '{1'b1, OP_DELETE, 32'd5,        '{5'd0,  1'b1, 32'd0, 32'd0,        32'd0}},
      // delete of a missing value reports the used size
      '{1'b1, OP_DELETE, 32'd7,        '{5'd16, 1'b0, 32'd0, 32'd0,        32'd0}},
      '{1'b1, OP_INSERT, 32'h7fffffff, '{5'd0,  1'b1, 32'd0, 32'h7fffffff, 32'd0}},
      // most negative value beats nothing: lands in the last used slot
      '{1'b1, OP_INSERT, 32'h80000000, '{5'd15, 1'b1, 32'd0, 32'h7fffffff, 32'h80000000}},
      // delete of the last used slot shifts nothing and keeps the entry
      '{1'b1, OP_DELETE, 32'h80000000, '{5'd15, 1'b1, 32'd0, 32'h7fffffff, 32'h80000000}},
      '{1'b0, OP_INSERT, 32'd100,      '0},
      '{1'b0, OP_INSERT, 32'd100,      '0},
      '{1'b0, OP_INSERT, 32'hfffffffb, '0},
      '{1'b0, OP_DELETE, 32'd100,      '0},
      '{1'b0, OP_DELETE, 32'd0,        '0},
      '{1'b0, OP_INSERT, 32'hffffffff, '0},
      '{1'b0, OP_INSERT, 32'd0,        '0},
      '{1'b0, OP_INSERT, 32'h55555555, '0},
      '{1'b0, OP_INSERT, 32'haaaaaaaa, '0},
      '{1'b0, OP_DELETE, 32'haaaaaaaa, '0},
      '{1'b0, OP_DELETE, 32'h7fffffff, '0},
      '{1'b0, OP_DELETE, 32'h00012345, '0},
      '{1'b0, OP_INSERT, 32'h7fffffff, '0},
      '{1'b0, OP_INSERT, 32'h80000000, '0}
   };

   // Register settings walked by the random phases; 0 and 31 exercise the
   // clamping of the used size at both ends.
   localparam int N_PHASES       = 9;
   localparam int ITEMS_PER_PHASE = 65;
   logic              phase_desc [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                                1'b1, 1'b0, 1'b1, 1'b1};
   logic [SIZE_W-1:0] phase_size [N_PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2,
                                                5'd17, 5'd8, 5'd0, 5'd16};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_mode  = 1'b0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [POS_W-1:0]         rsp_position;
   logic                     rsp_found;
   logic signed [DATA_W-1:0] rsp_dropped_value;
   logic signed [DATA_W-1:0] rsp_first_value;
   logic signed [DATA_W-1:0] rsp_last_value;
   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [ADDR_W-1:0]        paddr   = '0;
   logic [CSR_W-1:0]         pwdata  = '0;
   logic [CSR_W-1:0]         prdata;
   logic                     pready;

   // Mirror of the list and its registers, advanced once per accepted item.
   logic signed [DATA_W-1:0] list_mirror [DEPTH];
   logic                     order_desc;
   logic [SIZE_W-1:0]        size_reg;

   slot_report_type pending_reports [$];
   int              mismatch_count = 0;
   logic            idle_on = 1'b1;
   int              stall_run = 0;

   sorted_window_list i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position      (rsp_position),
      .rsp_found         (rsp_found),
      .rsp_dropped_value (rsp_dropped_value),
      .rsp_first_value   (rsp_first_value),
      .rsp_last_value    (rsp_last_value),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #4 clock = ~clock;

   // Number of slots in use: a size of zero counts as one, and sizes past
   // the depth saturate.
   function automatic int active_slots();
      if (size_reg == 0) return 1;
      if (size_reg > DEPTH) return DEPTH;
      return int'(size_reg);
   endfunction

   // Apply one operation to the mirror and return the report it produces.
   function automatic slot_report_type apply_to_list(swl_op_type op,
                                                     logic signed [DATA_W-1:0] v);
      int              n;
      int              pos;
      int              j;
      slot_report_type r;
      n = active_slots();
      r = '0;
      pos = 0;
      if (op == OP_INSERT) begin
         r.dropped = list_mirror[n-1];
         // advance past every entry the new value does not strictly beat
         while (pos < n - 1 &&
                !(order_desc ? (v > list_mirror[pos]) : (list_mirror[pos] > v)))
            pos++;
         for (j = n - 1; j > pos; j--) list_mirror[j] = list_mirror[j-1];
         list_mirror[pos] = v;
         r.found = 1'b1;
      end else begin
         while (pos < n && list_mirror[pos] != v) pos++;
         r.found = (pos < n);
         // close the gap; the last used slot keeps what it held
         if (r.found) begin
            for (j = pos; j < n - 1; j++) list_mirror[j] = list_mirror[j+1];
         end
      end
      r.position = POS_W'(pos);
      r.first    = list_mirror[0];
      r.last     = list_mirror[n-1];
      return r;
   endfunction

   // Offer one item, hold it until accepted, then record its expected report.
   task automatic push_item(swl_op_type op, logic [DATA_W-1:0] v, logic typed,
                            slot_report_type typed_report);
      int              gap;
      slot_report_type predicted;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= op;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      predicted = apply_to_list(op, v);
      pending_reports.push_back(typed ? typed_report : predicted);
   endtask

   // Each transfer ends with the bus returned to idle.
   task automatic write_register(swl_reg_type idx, logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_ORDER) order_desc = data[0];
      else size_reg = data[SIZE_W-1:0];
      @(posedge clock);
   endtask

   task automatic check_register(swl_reg_type idx, logic [CSR_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         mismatch_count++;
         $error("prdata reg %0d: expected %0h, actual %0h", idx, want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drain the result side, then let the pipeline settle before touching
   // configuration.
   task automatic wait_idle();
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic report_field(string name, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $error("%s: expected %0h, actual %0h", name, want, got);
      end
   endtask

   // Result stall: random bursts while idling is on.
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result item with the oldest expectation.
   always @(posedge clock) begin : check_results
      slot_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            $error("result item with nothing expected");
         end else begin
            want = pending_reports.pop_front();
            report_field("position", DATA_W'(want.position), DATA_W'(rsp_position));
            report_field("found", DATA_W'(want.found), DATA_W'(rsp_found));
            report_field("dropped_value", want.dropped, rsp_dropped_value);
            report_field("first_value", want.first, rsp_first_value);
            report_field("last_value", want.last, rsp_last_value);
         end
      end
   end

   initial begin : stimulus
      int                k;
      int                p;
      int                roll;
      swl_op_type        op;
      logic [DATA_W-1:0] v;
      for (k = 0; k < DEPTH; k++) list_mirror[k] = '0;
      order_desc = ORDER_RESET;
      size_reg   = SIZE_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers come out of reset at descending, full size
      check_register(REG_ORDER, CSR_W'(ORDER_RESET));
      check_register(REG_SIZE, CSR_W'(SIZE_RESET));

      for (k = 0; k < N_DIRECTED; k++)
         push_item(directed_rows[k].op, directed_rows[k].value,
                   directed_rows[k].typed, directed_rows[k].report);
      req_valid <= 1'b0;

      for (p = 0; p < N_PHASES; p++) begin
         wait_idle();
         // last phase and one middle phase run without any idling
         idle_on = (p != 3) && (p != N_PHASES - 1);
         write_register(REG_ORDER, CSR_W'(phase_desc[p]));
         write_register(REG_SIZE,
                        CSR_W'((p == 6) ? SIZE_W'($urandom_range(0, 31)) : phase_size[p]));
         check_register(REG_ORDER, CSR_W'(order_desc));
         check_register(REG_SIZE, CSR_W'(size_reg));
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            op   = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_DELETE;
            roll = $urandom_range(0, 9);
            // half of the deletes target a live entry so the shift path is hit
            if (op == OP_DELETE && roll < 5)
               v = list_mirror[$urandom_range(0, active_slots() - 1)];
            else if (roll < 6)
               v = $urandom_range(0, 16) - 8;
            else if (roll < 8)
               v = $urandom;
            else begin
               case ($urandom_range(0, 3))
                  0: v = 32'h7fffffff;
                  1: v = 32'h80000000;
                  2: v = 32'h0;
                  default: v = 32'hffffffff;
               endcase
            end
            push_item(op, v, 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sorted_window_list_tb: clean");
      end else begin
         $display("sorted_window_list_tb: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("sorted_window_list_tb: errors");
      $finish;
   end

endmodule
